/* hw/rtl/ntps_pkg.sv */
`timescale 1ns / 1ps

package ntps_pkg;

    // field widths
    localparam int unsigned TAG_W     = 32;
    localparam int unsigned ID_W      = 16;
    localparam int unsigned MESH_W    = 16;
    localparam int unsigned COORD_W   = 8;
    localparam int unsigned DIST_W    = 9;
    localparam int unsigned IN_IDX_W  = 5;
    // wide enough to compare any incoming index against a table depth up to 511
    localparam int unsigned CMP_IDX_W = 9;

    // action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // payload of one table slot
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [ID_W-1:0]   id;
        logic [MESH_W-1:0] address;
    } slot_t;

    // registered read response from the table
    typedef struct packed {
        logic  occupied;
        slot_t slot;
    } slot_rd_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_RESULT = 4'b1000
    } state_t;

    // manhattan distance between two packed mesh addresses
    function automatic logic [DIST_W-1:0] hop_count(
        input logic [MESH_W-1:0] from_addr,
        input logic [MESH_W-1:0] to_addr
    );
        logic [COORD_W-1:0] fx;
        logic [COORD_W-1:0] fy;
        logic [COORD_W-1:0] tx;
        logic [COORD_W-1:0] ty;
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
        fx = from_addr[MESH_W-1:COORD_W];
        fy = from_addr[COORD_W-1:0];
        tx = to_addr[MESH_W-1:COORD_W];
        ty = to_addr[COORD_W-1:0];
        dx = (fx >= tx) ? (fx - tx) : (tx - fx);
        dy = (fy >= ty) ? (fy - ty) : (ty - fy);
        return {1'b0, dx} + {1'b0, dy};
    endfunction

endpackage

/* hw/rtl/ntps_table.sv */
`timescale 1ns / 1ps

module ntps_table #(
    parameter int unsigned TABLE_DEPTH = 32,
    parameter int unsigned IDX_W       = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_index,
    input  logic                 wr_occupied,
    input  ntps_pkg::slot_t      wr_slot,
    input  logic [IDX_W-1:0]     rd_index,
    output ntps_pkg::slot_rd_t   rd
);

    // slot payload store, no reset: only occupied slots are ever used
    ntps_pkg::slot_t        mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] occupied_reg;
    ntps_pkg::slot_rd_t     rd_reg;

    // occupancy marks, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupied_reg <= '0;
        end
        else if (wr_en)
        begin
            occupied_reg[wr_index] <= wr_occupied;
        end
    end

    // single write port, single registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_index] <= wr_slot;
        end
        rd_reg.slot     <= mem[rd_index];
        rd_reg.occupied <= occupied_reg[rd_index];
    end

    assign rd = rd_reg;

endmodule

/* hw/rtl/nearest_tagged_provider_search.sv */
`timescale 1ns / 1ps

// Nearest tagged provider search.
// Input channel (in_valid/in_ready) carries one word per item. A word with
// action write stores or empties one table slot, or is dropped if its
// index lies beyond the table; it is taken while idle and gives no
// result. A word with action query scans the table and gives one result
// word on the output channel (out_valid/out_ready): found, the id and
// mesh address of the nearest slot whose tag holds every required bit,
// and the hop distance. Ties go to the lowest slot index. A query reads
// the table one slot per cycle through the single read port of the slot
// memory, compares the last slot in the drain state and loads the output
// register in the result state. The next word is taken only once the
// block is back in idle, so a new query is not taken before the last one
// is through. in_ready is high only in the idle state, while no query is
// in progress. The result sits in an output register, so the next word is
// accepted while a result still waits; a further query stalls in its
// result state until the receiver takes the earlier word.
// Reset empties every slot and clears both channels.

module nearest_tagged_provider_search #(
    parameter int unsigned TABLE_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [4:0]  entry_index,
    input  logic        entry_valid,
    input  logic [31:0] entry_tag,
    input  logic [15:0] entry_id,
    input  logic [15:0] entry_address,
    input  logic [15:0] query_address,
    input  logic [31:0] query_tag,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [15:0] provider_id,
    output logic [15:0] provider_address,
    output logic [8:0]  hop_distance
);

    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [ntps_pkg::CMP_IDX_W-1:0] DEPTH_CMP =
        ntps_pkg::CMP_IDX_W'(TABLE_DEPTH);

    ntps_pkg::state_t state_reg, state_next;

    logic [IDX_W-1:0]            ptr_reg, ptr_next;
    logic                        cmp_en_reg, cmp_en_next;
    logic [ntps_pkg::MESH_W-1:0] qaddr_reg;
    logic [ntps_pkg::TAG_W-1:0]  qtag_reg;

    logic                        hit_reg, hit_next;
    logic [ntps_pkg::DIST_W-1:0] best_dist_reg, best_dist_next;
    logic [ntps_pkg::ID_W-1:0]   best_id_reg, best_id_next;
    logic [ntps_pkg::MESH_W-1:0] best_addr_reg, best_addr_next;

    logic                        out_valid_reg, out_valid_next;
    logic                        found_reg;
    logic [ntps_pkg::ID_W-1:0]   id_reg;
    logic [ntps_pkg::MESH_W-1:0] addr_reg;
    logic [ntps_pkg::DIST_W-1:0] dist_reg;

    logic                               accept;
    logic                               wr_en;
    logic [ntps_pkg::CMP_IDX_W-1:0]     idx_ext;
    ntps_pkg::slot_t                    wr_slot;
    ntps_pkg::slot_rd_t                 rd;
    logic                               matched;
    logic [ntps_pkg::DIST_W-1:0]        cand_dist;
    logic                               load_out;

    assign accept = in_valid && in_ready;

    // writes beyond the table are dropped
    assign idx_ext = ntps_pkg::CMP_IDX_W'(entry_index);
    assign wr_en   = accept && (action == ntps_pkg::ACT_WRITE) && (idx_ext < DEPTH_CMP);

    assign wr_slot.tag     = entry_tag;
    assign wr_slot.id      = entry_id;
    assign wr_slot.address = entry_address;

    ntps_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_index    (idx_ext[IDX_W-1:0]),
        .wr_occupied (entry_valid),
        .wr_slot     (wr_slot),
        .rd_index    (ptr_reg),
        .rd          (rd)
    );

    // compare stage on the slot read in the previous cycle
    assign matched   = rd.occupied && ((rd.slot.tag & qtag_reg) == qtag_reg);
    assign cand_dist = ntps_pkg::hop_count(qaddr_reg, rd.slot.address);

    assign load_out = (state_reg == ntps_pkg::S_RESULT) && (!out_valid_reg || out_ready);

    // sequencer and running best
    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        cmp_en_next    = 1'b0;
        hit_next       = hit_reg;
        best_dist_next = best_dist_reg;
        best_id_next   = best_id_reg;
        best_addr_next = best_addr_reg;

        if (cmp_en_reg && matched && (!hit_reg || (cand_dist < best_dist_reg)))
        begin
            hit_next       = 1'b1;
            best_dist_next = cand_dist;
            best_id_next   = rd.slot.id;
            best_addr_next = rd.slot.address;
        end

        unique case (state_reg)
            ntps_pkg::S_IDLE:
            begin
                if (accept && (action == ntps_pkg::ACT_QUERY))
                begin
                    state_next     = ntps_pkg::S_SCAN;
                    ptr_next       = '0;
                    hit_next       = 1'b0;
                    best_dist_next = '0;
                    best_id_next   = '0;
                    best_addr_next = '0;
                end
            end
            ntps_pkg::S_SCAN:
            begin
                cmp_en_next = 1'b1;
                if (ptr_reg == LAST_IDX)
                begin
                    state_next = ntps_pkg::S_DRAIN;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ntps_pkg::S_DRAIN:
            begin
                state_next = ntps_pkg::S_RESULT;
            end
            ntps_pkg::S_RESULT:
            begin
                if (load_out)
                begin
                    state_next = ntps_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ntps_pkg::S_IDLE;
            end
        endcase
    end

    // output register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ntps_pkg::S_IDLE;
            ptr_reg       <= '0;
            cmp_en_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            cmp_en_reg    <= cmp_en_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // query operands, running best and result word
    always_ff @(posedge clk)
    begin
        if (accept && (action == ntps_pkg::ACT_QUERY))
        begin
            qaddr_reg <= query_address;
            qtag_reg  <= query_tag;
        end
        hit_reg       <= hit_next;
        best_dist_reg <= best_dist_next;
        best_id_reg   <= best_id_next;
        best_addr_reg <= best_addr_next;
        if (load_out)
        begin
            found_reg <= hit_reg;
            id_reg    <= best_id_reg;
            addr_reg  <= best_addr_reg;
            dist_reg  <= best_dist_reg;
        end
    end

    assign in_ready         = (state_reg == ntps_pkg::S_IDLE);
    assign out_valid        = out_valid_reg;
    assign found            = found_reg;
    assign provider_id      = id_reg;
    assign provider_address = addr_reg;
    assign hop_distance     = dist_reg;

    // a new result word only follows the result cycle of a query
    a_result_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ntps_pkg::S_RESULT))
        else $error("result word without a finished scan");

    // a query starts its scan at slot zero
    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (action == ntps_pkg::ACT_QUERY))
            |=> (state_reg == ntps_pkg::S_SCAN) && (ptr_reg == '0))
        else $error("scan did not start at slot zero");

    // no match leaves every result field at zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found)
            |-> (provider_id == '0) && (provider_address == '0) && (hop_distance == '0))
        else $error("miss result carries non-zero fields");

    // the scan pointer never leaves the table
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ntps_pkg::S_SCAN) |-> (ptr_reg <= LAST_IDX))
        else $error("scan pointer beyond table");

endmodule

/* dv/nearest_tagged_provider_search_test.sv */
`timescale 1ns / 1ps

module nearest_tagged_provider_search_test;

    localparam int DEPTH        = 32;
    localparam int RANDOM_WORDS = 580;
    localparam int HOLD_WORDS   = 24;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 48;
    localparam int CYCLE_LIMIT  = 200000;

    // one query answer as it leaves the block
    typedef struct packed {
        logic                        found;
        logic [ntps_pkg::ID_W-1:0]   id;
        logic [ntps_pkg::MESH_W-1:0] address;
        logic [ntps_pkg::DIST_W-1:0] hops;
    } match_t;

    // one input word, with an optional hand-written answer
    typedef struct packed {
        logic                        action;
        logic [4:0]                  index;
        logic                        occupy;
        logic [ntps_pkg::TAG_W-1:0]  tag;
        logic [ntps_pkg::ID_W-1:0]   id;
        logic [ntps_pkg::MESH_W-1:0] address;
        logic [ntps_pkg::MESH_W-1:0] from;
        logic [ntps_pkg::TAG_W-1:0]  need;
        logic                        known;
        match_t                      answer;
    } request_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        action = ntps_pkg::ACT_WRITE;
    logic [4:0]  entry_index = '0;
    logic        entry_valid = 1'b0;
    logic [31:0] entry_tag = '0;
    logic [15:0] entry_id = '0;
    logic [15:0] entry_address = '0;
    logic [15:0] query_address = '0;
    logic [31:0] query_tag = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        found;
    logic [15:0] provider_id;
    logic [15:0] provider_address;
    logic [8:0]  hop_distance;

    // hand-written answer travelling alongside the word on offer
    logic        offered_known = 1'b0;
    match_t      offered_answer = '0;

    // shadow of the provider table
    logic                        tbl_valid [DEPTH];
    logic [ntps_pkg::TAG_W-1:0]  tbl_tag [DEPTH];
    logic [ntps_pkg::ID_W-1:0]   tbl_id [DEPTH];
    logic [ntps_pkg::MESH_W-1:0] tbl_address [DEPTH];

    match_t      pending_matches[$];
    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    bit          no_idle = 1'b0;
    bit          hold_request = 1'b0;

    nearest_tagged_provider_search dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .action           (action),
        .entry_index      (entry_index),
        .entry_valid      (entry_valid),
        .entry_tag        (entry_tag),
        .entry_id         (entry_id),
        .entry_address    (entry_address),
        .query_address    (query_address),
        .query_tag        (query_tag),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .found            (found),
        .provider_id      (provider_id),
        .provider_address (provider_address),
        .hop_distance     (hop_distance)
    );

    always #1 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic flag(input string what, input logic [31:0] got, input logic [31:0] want);
        mismatches++;
        $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    endtask

    // manhattan distance on the 8x8-bit mesh
    function automatic logic [ntps_pkg::DIST_W-1:0] mesh_hops(
        input logic [ntps_pkg::MESH_W-1:0] a,
        input logic [ntps_pkg::MESH_W-1:0] b
    );
        int dx;
        int dy;
        dx = int'(a[15:8]) - int'(b[15:8]);
        dy = int'(a[7:0]) - int'(b[7:0]);
        if (dx < 0)
            dx = -dx;
        if (dy < 0)
            dy = -dy;
        return ntps_pkg::DIST_W'(dx + dy);
    endfunction

    // nearest occupied slot holding every required tag bit, lowest index on a tie
    function automatic match_t nearest_match(input logic [ntps_pkg::MESH_W-1:0] from,
                                             input logic [ntps_pkg::TAG_W-1:0] need);
        match_t                      best;
        logic [ntps_pkg::DIST_W-1:0] d;
        best = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (tbl_valid[i] && (tbl_tag[i] & need) == need)
            begin
                d = mesh_hops(from, tbl_address[i]);
                if (!best.found || d < best.hops)
                    best = '{1'b1, tbl_id[i], tbl_address[i], d};
            end
        end
        return best;
    endfunction

    // shadow table update and expectation on every accepted input word
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            if (action == ntps_pkg::ACT_WRITE)
            begin
                tbl_valid[entry_index]   = entry_valid;
                tbl_tag[entry_index]     = entry_tag;
                tbl_id[entry_index]      = entry_id;
                tbl_address[entry_index] = entry_address;
            end
            else if (offered_known)
                pending_matches.push_back(offered_answer);
            else
                pending_matches.push_back(nearest_match(query_address, query_tag));
        end
    end

    // result checking
    always @(posedge clk)
    begin
        match_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_matches.size() == 0)
                flag("result with nothing expected, id", 32'(provider_id), 32'd0);
            else
            begin
                want = pending_matches.pop_front();
                if (found !== want.found)
                    flag("found", 32'(found), 32'(want.found));
                if (provider_id !== want.id)
                    flag("provider_id", 32'(provider_id), 32'(want.id));
                if (provider_address !== want.address)
                    flag("provider_address", 32'(provider_address), 32'(want.address));
                if (hop_distance !== want.hops)
                    flag("hop_distance", 32'(hop_distance), 32'(want.hops));
            end
        end
    end

    function automatic int pick_gap();
        return no_idle ? 0 : $urandom_range(0, 7);
    endfunction

    // receiver: random stalls, with a long hold-off on request
    initial
    begin : result_sink
        int stall;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = pick_gap();
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid && !hold_request);
        end
    end

    function automatic request_t store(input logic [4:0] index, input logic occupy,
                                       input logic [31:0] tag, input logic [15:0] id,
                                       input logic [15:0] address);
        request_t r;
        r = '0;
        r.action  = ntps_pkg::ACT_WRITE;
        r.index   = index;
        r.occupy  = occupy;
        r.tag     = tag;
        r.id      = id;
        r.address = address;
        return r;
    endfunction

    function automatic request_t ask(input logic [15:0] from, input logic [31:0] need);
        request_t r;
        r = '0;
        r.action = ntps_pkg::ACT_QUERY;
        r.from   = from;
        r.need   = need;
        return r;
    endfunction

    function automatic request_t ask_known(input logic [15:0] from, input logic [31:0] need,
                                           input logic f, input logic [15:0] id,
                                           input logic [15:0] address, input logic [8:0] hops);
        request_t r;
        r = ask(from, need);
        r.known  = 1'b1;
        r.answer = '{f, id, address, hops};
        return r;
    endfunction

    // mesh address: half the time a small corner to force ties, some far corners, the rest anywhere
    function automatic logic [15:0] pick_address();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 10)
            return {8'($urandom_range(0, 3)), 8'($urandom_range(0, 3))};
        else if (sel < 13)
            return {($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00,
                    ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00};
        else
            return 16'($urandom);
    endfunction

    function automatic request_t random_request(input bit query_only);
        request_t                   r;
        logic [ntps_pkg::TAG_W-1:0] tag;
        int                         sel;
        if (!query_only && $urandom_range(0, 99) < 45)
        begin
            sel = $urandom_range(0, 7);
            tag = (sel == 0) ? 32'hFFFF_FFFF : (sel == 1) ? 32'h0 : ($urandom | $urandom);
            r = store(5'($urandom), ($urandom_range(0, 4) != 0), tag, 16'($urandom),
                      pick_address());
        end
        else
        begin
            sel = $urandom_range(0, 9);
            case (sel)
                0:       tag = 32'h0;
                1:       tag = $urandom;
                2, 3, 4,
                5:       tag = tbl_tag[$urandom_range(0, DEPTH - 1)] & $urandom;
                9:       tag = 32'hFFFF_FFFF;
                default: tag = $urandom & $urandom & $urandom;
            endcase
            r = ask(pick_address(), tag);
        end
        return r;
    endfunction

    // sender: optional gap, then hold the word until it is taken
    task automatic offer_word(input request_t r);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        action         <= r.action;
        entry_index    <= r.index;
        entry_valid    <= r.occupy;
        entry_tag      <= r.tag;
        entry_id       <= r.id;
        entry_address  <= r.address;
        query_address  <= r.from;
        query_tag      <= r.need;
        offered_known  <= r.known;
        offered_answer <= r.answer;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_matches.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        request_t plan[$];

        for (int i = 0; i < DEPTH; i++)
        begin
            tbl_valid[i]   = 1'b0;
            tbl_tag[i]     = '0;
            tbl_id[i]      = '0;
            tbl_address[i] = '0;
        end

        plan = '{
            // empty table after reset
            ask_known(16'h0000, 32'h0, 1'b0, 16'h0, 16'h0, 9'd0),
            ask_known(16'hFFFF, 32'hFFFF_FFFF, 1'b0, 16'h0, 16'h0, 9'd0),
            // far corners, all-ones tag
            store(5'd0, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF),
            ask_known(16'h0000, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 16'hFFFF, 9'd510),
            ask_known(16'hFFFF, 32'h0, 1'b1, 16'hFFFF, 16'hFFFF, 9'd0),
            store(5'd31, 1'b1, 32'h0, 16'h0000, 16'h0000),
            ask_known(16'h0000, 32'h0, 1'b1, 16'h0000, 16'h0000, 9'd0),
            ask_known(16'h0000, 32'h1, 1'b1, 16'hFFFF, 16'hFFFF, 9'd510),
            ask(16'hFF00, 32'h0),
            // emptied slot no longer answers
            store(5'd0, 1'b0, 32'hFFFF_FFFF, 16'h1234, 16'h0000),
            ask_known(16'h0000, 32'h1, 1'b0, 16'h0, 16'h0, 9'd0),
            // ties and partial tag matches
            store(5'd5, 1'b1, 32'h0000_00F0, 16'h0055, 16'h0A0A),
            store(5'd12, 1'b1, 32'h0000_00FF, 16'h00CC, 16'h0B0B),
            store(5'd9, 1'b1, 32'hA5A5_5AF0, 16'h0099, 16'h0808),
            ask(16'h0B0A, 32'h0000_0080),
            ask(16'h0909, 32'h0000_0010),
            ask(16'h00FF, 32'h0000_00F0),
            ask(16'hFFFF, 32'h0000_0001),
            store(5'd31, 1'b0, 32'h0, 16'h0, 16'h0),
            ask(16'h8080, 32'h0),
            store(5'd20, 1'b1, 32'h8000_0000, 16'h8001, 16'hFF00),
            ask(16'hFF01, 32'h8000_0000)
        };

        // reset
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words
        foreach (plan[i])
            offer_word(plan[i]);
        wait_drained();

        // random words with idling on both sides
        for (int n = 0; n < RANDOM_WORDS / 3; n++)
            offer_word(random_request(1'b0));

        // back-to-back stretch
        no_idle = 1'b1;
        for (int n = 0; n < RANDOM_WORDS / 4; n++)
            offer_word(random_request(1'b0));

        // receiver holds off while queries keep coming, so the block backs up
        hold_request = 1'b1;
        for (int n = 0; n < HOLD_WORDS; n++)
            offer_word(random_request(1'b1));
        no_idle = 1'b0;
        wait_drained();

        for (int n = RANDOM_WORDS / 3 + RANDOM_WORDS / 4; n < RANDOM_WORDS; n++)
            offer_word(random_request(1'b0));

        // drain and settle
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
